FILE: rtl/masked_byte_pattern_search_defines.svh
// Assertion helpers shared by the checker files.
`ifndef MASKED_BYTE_PATTERN_SEARCH_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBPS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("masked byte pattern search check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MBPS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("masked byte pattern search check failed");

`endif

FILE: rtl/mbps_pkg.sv
package mbps_pkg;

    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 64;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int SIG_BYTES  = 16;
    localparam int SIG_IDX_W  = 4;
    localparam int LEN_W      = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMPARE_MASK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE  = 3'd4;

    typedef logic [SIG_BYTES-1:0][BYTE_W-1:0] signature_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } result_t;

endpackage

FILE: rtl/masked_byte_pattern_search.sv
// Masked byte pattern search.
// Configure through cfg_we/cfg_index/cfg_data while the block is idle:
// pattern bytes low and high, compare mask, pattern length, region base.
// Stream a region one byte per transaction on data_byte, with last_byte set
// on its final byte. Each region yields exactly one result: found=1 and the
// address of the first match as soon as the match completes, or found=0 with
// address 0 on the last byte when nothing matched.
// The input side takes one byte per cycle while in_ready is high; each result
// is registered in the output buffer before it shows on out_valid. The window
// is a row of byte cells that all compare in parallel, so the rate is set
// only by the handshake. Results pass through a two-entry output buffer:
// while the receiver stalls, input continues until both entries are held,
// then in_ready drops until out_ready takes one.
// Reset clears the byte counter, the match flag and the output buffer, and
// loads the register defaults (mask all ones, length one, the rest zero).
module masked_byte_pattern_search #(
    parameter int MAX_PATTERN_LEN = 16,
    parameter int OFFSET_WIDTH    = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [mbps_pkg::BYTE_W-1:0]      data_byte,
    input  logic                             last_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             found,
    output logic [mbps_pkg::ADDR_W-1:0]      match_address
);

    logic [63:0]                        pattern_low_reg;
    logic [63:0]                        pattern_high_reg;
    logic [mbps_pkg::SIG_BYTES-1:0]     compare_mask_reg;
    logic [mbps_pkg::LEN_W-1:0]         pattern_length_reg;
    logic [mbps_pkg::ADDR_W-1:0]        region_base_reg;

    logic [OFFSET_WIDTH-1:0]            bytes_seen_reg, bytes_seen_next;
    logic                               reported_reg, reported_next;

    mbps_pkg::signature_t               signature;
    logic [mbps_pkg::LEN_W-1:0]         len_act;
    logic [mbps_pkg::LEN_W-1:0]         len_m1;
    logic [MAX_PATTERN_LEN-1:0]         cell_hit;
    logic [mbps_pkg::BYTE_W-1:0]        cell_byte [MAX_PATTERN_LEN+1];
    logic                               accept;
    logic                               counted;
    logic                               hit;
    logic [OFFSET_WIDTH-1:0]            start_offset;
    logic                               res_valid;
    mbps_pkg::result_t                  res;
    mbps_pkg::result_t                  out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            compare_mask_reg   <= '1;
            pattern_length_reg <= mbps_pkg::LEN_W'(1);
            region_base_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mbps_pkg::REG_PATTERN_LOW:  pattern_low_reg    <= cfg_data;
                mbps_pkg::REG_PATTERN_HIGH: pattern_high_reg   <= cfg_data;
                mbps_pkg::REG_COMPARE_MASK:
                    compare_mask_reg <= cfg_data[mbps_pkg::SIG_BYTES-1:0];
                mbps_pkg::REG_PATTERN_LEN:
                    pattern_length_reg <= cfg_data[mbps_pkg::LEN_W-1:0];
                mbps_pkg::REG_REGION_BASE:  region_base_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign signature = {pattern_high_reg, pattern_low_reg};

    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            len_act = mbps_pkg::LEN_W'(1);
        end
        else if (pattern_length_reg > mbps_pkg::LEN_W'(MAX_PATTERN_LEN))
        begin
            len_act = mbps_pkg::LEN_W'(MAX_PATTERN_LEN);
        end
        else
        begin
            len_act = pattern_length_reg;
        end
    end

    assign len_m1 = len_act - mbps_pkg::LEN_W'(1);

    assign accept = in_valid && in_ready;

    // Window: cell k compares the byte received k transactions ago
    assign cell_byte[0] = data_byte;

    for (genvar k = 0; k < MAX_PATTERN_LEN; k++)
    begin : g_cell
        mbps_cell #(
            .IDX (k)
        ) u_cell (
            .clk          (clk),
            .shift_en     (accept),
            .byte_in      (cell_byte[k]),
            .byte_out     (cell_byte[k+1]),
            .signature    (signature),
            .compare_mask (compare_mask_reg),
            .pattern_len  (len_act),
            .hit          (cell_hit[k])
        );
    end

    // Count saturates; a saturated count can no longer complete a match
    assign counted      = bytes_seen_reg != '1;
    assign start_offset = bytes_seen_reg - OFFSET_WIDTH'(len_m1);
    assign hit = counted && !reported_reg
               && (bytes_seen_reg >= OFFSET_WIDTH'(len_m1)) && (&cell_hit);

    assign res_valid = accept && (hit || (last_byte && !reported_reg));
    assign res.found = hit;
    assign res.match_address = hit ? region_base_reg + mbps_pkg::ADDR_W'(start_offset)
                                   : '0;

    always_comb
    begin
        bytes_seen_next = bytes_seen_reg;
        reported_next   = reported_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                bytes_seen_next = '0;
                reported_next   = 1'b0;
            end
            else
            begin
                if (counted)
                begin
                    bytes_seen_next = bytes_seen_reg + OFFSET_WIDTH'(1);
                end
                if (hit)
                begin
                    reported_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg <= '0;
            reported_reg   <= 1'b0;
        end
        else
        begin
            bytes_seen_reg <= bytes_seen_next;
            reported_reg   <= reported_next;
        end
    end

    mbps_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .space     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign found         = out_res.found;
    assign match_address = out_res.match_address;

endmodule

FILE: rtl/mbps_cell.sv
module mbps_cell #(
    parameter int IDX = 0
) (
    input  logic                           clk,
    input  logic                           shift_en,
    input  logic [mbps_pkg::BYTE_W-1:0]    byte_in,
    output logic [mbps_pkg::BYTE_W-1:0]    byte_out,
    input  mbps_pkg::signature_t           signature,
    input  logic [mbps_pkg::SIG_BYTES-1:0] compare_mask,
    input  logic [mbps_pkg::LEN_W-1:0]     pattern_len,
    output logic                           hit
);

    logic [mbps_pkg::BYTE_W-1:0]    byte_reg;
    logic                           in_use;
    logic [mbps_pkg::LEN_W-1:0]     sig_pos;
    logic [mbps_pkg::SIG_IDX_W-1:0] sig_sel;

    // This cell compares the byte received IDX transactions ago; it lines up
    // with signature byte (length - 1 - IDX).
    assign in_use  = mbps_pkg::LEN_W'(IDX) < pattern_len;
    assign sig_pos = pattern_len - mbps_pkg::LEN_W'(1) - mbps_pkg::LEN_W'(IDX);
    assign sig_sel = sig_pos[mbps_pkg::SIG_IDX_W-1:0];

    // Compare the byte entering the cell this cycle
    assign hit = !in_use || !compare_mask[sig_sel] || (byte_in == signature[sig_sel]);

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

endmodule

FILE: rtl/mbps_out_buf.sv
module mbps_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_valid,
    input  mbps_pkg::result_t   res,
    output logic                space,
    output logic                out_valid,
    input  logic                out_ready,
    output mbps_pkg::result_t   out_res
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    mbps_pkg::result_t out_res_reg, out_res_next;
    mbps_pkg::result_t skid_res_reg, skid_res_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                // drain skid entry first; no new result can arrive while it is full
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_res_next   = res;
            end
        end
        else if (res_valid)
        begin
            // output stalled: park the new result
            skid_valid_next = 1'b1;
            skid_res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

FILE: rtl/mbps_checker.sv
`include "masked_byte_pattern_search_defines.svh"

module mbps_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        found,
    input logic [mbps_pkg::ADDR_W-1:0] match_address
);

    // a miss reports address zero
    `MBPS_ASSERT_IMPL(a_miss_addr_zero, clk, rst_n, out_valid && !found, match_address == '0)

    // a new result only follows an accepted byte
    `MBPS_ASSERT_IMPL(a_result_after_input, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready))

    // input only backs up when a result is pending
    `MBPS_ASSERT_IMPL(a_stall_needs_result, clk, rst_n, !in_ready, out_valid)

    // hold a stalled result
    `MBPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(found) && $stable(match_address))

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .found         (found),
    .match_address (match_address)
);
